### rtl/core/ic2d_pkg.sv
// ----------------------------------------------------------------------------
// ic2d_pkg: shared constants and types of the 2D convolution block
// Kernel geometry, field widths, the reciprocal used for normalization and the
// structures that travel between the line buffer, MAC pipeline and result FIFO.
// ----------------------------------------------------------------------------
package ic2d_pkg;

    localparam int KERNEL_SIZE = 3;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;

    localparam int HALF      = KERNEL_SIZE / 2;
    localparam int AREA      = KERNEL_SIZE * KERNEL_SIZE;
    localparam int PIX_W     = 8;
    localparam int PIXEL_MAX = 255;

    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = 12;
    localparam int OUT_COL_W    = 10;
    localparam int WIDTH_CFG_W  = 11;
    localparam int HEIGHT_CFG_W = 13;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int COEFS_PER_REG = CFG_DATA_W / PIX_W;

    localparam int RESET_WIDTH  = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
    localparam int RESET_HEIGHT = 1024;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_0    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = CFG_IDX_W'(6);

    // Arithmetic widths: signed coefficient times unsigned pixel, then sums.
    localparam int PROD_W = 2 * PIX_W + 1;
    localparam int RSUM_W = PROD_W + $clog2(KERNEL_SIZE);
    localparam int SUM_W  = RSUM_W + $clog2(KERNEL_SIZE);

    // Floor division by the kernel area as a multiply by a rounded-up
    // reciprocal. Only sums below NORM_LIM need it; larger ones saturate.
    localparam int NORM_LIM = (PIXEL_MAX + 1) * AREA;
    localparam int QN_W     = $clog2(NORM_LIM);
    localparam int RECIP_SH = QN_W + $clog2(AREA);
    localparam int RECIP_M  = ((1 << RECIP_SH) + AREA - 1) / AREA;
    localparam int QPROD_W  = QN_W + RECIP_SH;

    // Pipeline and result queue sizing. FIFO_DEPTH is a power of two.
    localparam int MAC_STAGES   = 4;
    localparam int PIPE_STAGES  = MAC_STAGES + 1;
    localparam int RES_PER_ITEM = 2;
    localparam int FIFO_DEPTH   = 16;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = FIFO_PTR_W + 1;
    localparam int INFL_W       = $clog2(PIPE_STAGES + 1);
    localparam int CRED_W       = FIFO_CNT_W + 2;

    typedef logic [PIX_W-1:0] t_pix;

    // One line buffer entry: the pixels of the previous rows at one column,
    // element 0 is the oldest row.
    typedef logic [KERNEL_SIZE-2:0][PIX_W-1:0] t_line;

    // One window column, element 0 is the top row.
    typedef logic [KERNEL_SIZE-1:0][PIX_W-1:0] t_col;

    typedef logic [AREA-1:0][PIX_W-1:0] t_coefs;

    typedef struct packed {
        logic             interior;
        logic             border;
        t_pix             pixel;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_tag;

    typedef struct packed {
        t_pix                 pixel;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic                 filtered;
        logic                 last;
    } t_res;

    typedef struct packed {
        logic valid;
        t_res res;
    } t_push;

endpackage

### rtl/core/ic2d_line_buf.sv
// ----------------------------------------------------------------------------
// ic2d_line_buf: line buffer of the previous kernel rows
// One entry per column holds the earlier rows at that column. Synchronous read
// with a registered output; a write to the address being read is forwarded.
// ----------------------------------------------------------------------------
module ic2d_line_buf import ic2d_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [COL_W-1:0] i_rd_addr,
    output t_line            o_rd_data,
    input  logic             i_wr_en,
    input  logic [COL_W-1:0] i_wr_addr,
    input  t_line            i_wr_data
);

    t_line r_mem [MAX_WIDTH];
    t_line r_rd;
    t_line r_fwd;
    logic  r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    // With a one-pixel-wide frame every item reads the entry that the
    // previous item writes back in the same cycle.
    always_ff @(posedge i_clk) begin
        r_fwd_hit <= i_rd_en && i_wr_en && (i_wr_addr == i_rd_addr);
        r_fwd     <= i_wr_data;
    end

    assign o_rd_data = r_fwd_hit ? r_fwd : r_rd;

endmodule

### rtl/core/ic2d_mac.sv
// ----------------------------------------------------------------------------
// ic2d_mac: window register and multiply-accumulate pipeline
// Shifts a column into the KxK window per item, multiplies by the kernel,
// sums by rows and then in total, and clamps or normalizes the sum.
// ----------------------------------------------------------------------------
module ic2d_mac import ic2d_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_shift,
    input  t_col                  i_col,
    input  t_tag                  i_tag,
    input  t_coefs                i_coefs,
    input  logic                  i_normalize,
    output logic [MAC_STAGES-1:0] o_stage_v,
    output logic                  o_res_v,
    output t_tag                  o_tag,
    output t_pix                  o_value
);

    logic [PIX_W-1:0]         r_win [KERNEL_SIZE][KERNEL_SIZE];
    logic [MAC_STAGES-1:0]    r_v;
    t_tag                     r_tag [MAC_STAGES];
    logic signed [PROD_W-1:0] r_prod [AREA];
    logic signed [RSUM_W-1:0] r_rsum [KERNEL_SIZE];
    logic signed [SUM_W-1:0]  r_sum;

    logic signed [PROD_W-1:0] n_prod [AREA];
    logic signed [RSUM_W-1:0] n_rsum [KERNEL_SIZE];
    logic signed [SUM_W-1:0]  n_sum;
    logic [SUM_W-1:0]         sum_u;
    logic [QPROD_W-1:0]       q_prod;

    // Column 0 of the window is the oldest column.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            for (int i = 0; i < KERNEL_SIZE; i++) begin
                for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
                    r_win[i][j] <= r_win[i][j+1];
                end
                r_win[i][KERNEL_SIZE-1] <= i_col[i];
            end
        end
    end

    always_comb begin
        for (int n = 0; n < AREA; n++) begin
            n_prod[n] = $signed({{(PROD_W-PIX_W){i_coefs[n][PIX_W-1]}}, i_coefs[n]})
                      * $signed({{(PROD_W-PIX_W){1'b0}},
                                 r_win[n / KERNEL_SIZE][n % KERNEL_SIZE]});
        end
    end

    always_comb begin
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            n_rsum[i] = '0;
            for (int j = 0; j < KERNEL_SIZE; j++) begin
                n_rsum[i] = n_rsum[i] + RSUM_W'(r_prod[i*KERNEL_SIZE + j]);
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            n_sum = n_sum + SUM_W'(r_rsum[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[MAC_STAGES-2:0], i_shift};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_tag;
        for (int k = 1; k < MAC_STAGES; k++) begin
            r_tag[k] <= r_tag[k-1];
        end
        r_prod <= n_prod;
        r_rsum <= n_rsum;
        r_sum  <= n_sum;
    end

    assign sum_u = r_sum;

    // A negative sum gives zero; when normalizing, sums at or above 256 times
    // the area saturate, so the reciprocal multiply only sees the low bits.
    always_comb begin
        q_prod = QPROD_W'(sum_u[QN_W-1:0]) * QPROD_W'(RECIP_M);
        if (sum_u[SUM_W-1]) begin
            o_value = '0;
        end else if (i_normalize) begin
            o_value = (sum_u >= SUM_W'(NORM_LIM)) ? PIX_W'(PIXEL_MAX)
                                                   : q_prod[RECIP_SH +: PIX_W];
        end else begin
            o_value = (sum_u > SUM_W'(PIXEL_MAX)) ? PIX_W'(PIXEL_MAX)
                                                   : sum_u[PIX_W-1:0];
        end
    end

    assign o_stage_v = r_v;
    assign o_res_v   = r_v[MAC_STAGES-1];
    assign o_tag     = r_tag[MAC_STAGES-1];

endmodule

### rtl/core/ic2d_res_fifo.sv
// ----------------------------------------------------------------------------
// ic2d_res_fifo: result queue with two write slots and one read port
// Takes up to two results per cycle in order and offers one per cycle to the
// downstream side, which may stall it.
// ----------------------------------------------------------------------------
module ic2d_res_fifo import ic2d_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_push                 i_push0,
    input  t_push                 i_push1,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_res                  o_res,
    output logic [FIFO_CNT_W-1:0] o_count
);

    t_res                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wptr;
    logic [FIFO_PTR_W-1:0] r_rptr;
    logic [FIFO_CNT_W-1:0] r_count;

    logic [FIFO_PTR_W-1:0] wptr_nx;
    logic [FIFO_CNT_W-1:0] push_n;
    logic                  pop;

    assign wptr_nx = r_wptr + FIFO_PTR_W'(1);
    assign push_n  = FIFO_CNT_W'(i_push0.valid) + FIFO_CNT_W'(i_push1.valid);
    assign pop     = (r_count != '0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push0.valid) begin
            r_mem[r_wptr] <= i_push0.res;
        end
        if (i_push1.valid) begin
            r_mem[wptr_nx] <= i_push1.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + FIFO_PTR_W'(push_n);
            r_rptr  <= r_rptr + FIFO_PTR_W'(pop);
            r_count <= r_count + push_n - FIFO_CNT_W'(pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rptr];
    assign o_count = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue holds more than its depth");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push1.valid |-> i_push0.valid)
        else $error("second result slot written without the first");

    a_stall_no_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (r_count >= $past(r_count)))
        else $error("result queue drained while the receiver stalled");

endmodule

### rtl/core/image_2d_convolution_clamp_top.sv
// ----------------------------------------------------------------------------
// image_2d_convolution_clamp_top: KxK convolution of a raster pixel stream
//
// Pixels enter in raster order on i_valid/o_stall/i_pixel, one item per
// cycle while o_stall is low. Each item gives zero, one or two results on
// o_valid/i_stall: the filtered centre of a window completed by this pixel
// first, then the pixel itself if it lies on the border. Every result carries
// its row and column, and o_last_of_item marks the final result of an item.
// The line buffer read, window shift, multiply, row sum and total sum stages
// are each registered before results are written into the queue, so a new
// item can enter every cycle while o_stall is low. Results leave through a
// 16-entry queue at one per cycle while i_stall is low;
// o_stall rises when queue occupancy plus two per item in the pipeline plus
// two exceeds 16, so items that give two results slow the input to the
// output rate. While the receiver stalls, finished results wait in the
// queue and the input keeps being taken until that bound is reached.
// Configuration writes on i_cfg_valid/o_cfg_ready are taken only while no
// item is in the pipeline: o_cfg_ready is low while any item is, and a
// pending write holds o_stall high so that no item enters beside it.
// Reset restores the default kernel and
// geometry, empties pipeline and queue and starts a new frame at row 0,
// column 0. The line buffer is not cleared.
// ----------------------------------------------------------------------------
module image_2d_convolution_clamp_top import ic2d_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [PIX_W-1:0]      i_pixel,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic [ROW_W-1:0]      o_out_row,
    output logic [OUT_COL_W-1:0]  o_out_column,
    output logic                  o_is_filtered,
    output logic                  o_last_of_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_coefs                  r_coefs;
    logic                    r_normalize;
    logic [COL_W:0]          r_width;
    logic [HEIGHT_CFG_W-1:0] r_height;
    logic [ROW_W-1:0]        r_row;
    logic [COL_W-1:0]        r_col;
    logic                    r_s1_valid;
    t_tag                    r_s1_tag;

    logic [COL_W:0]          n_width;
    logic [HEIGHT_CFG_W-1:0] n_height;
    logic [WIDTH_CFG_W-1:0]  cfg_w;
    logic [HEIGHT_CFG_W-1:0] cfg_h;
    logic                    in_accept;
    logic [COL_W:0]          col_inc;
    logic [HEIGHT_CFG_W-1:0] row_inc;
    logic                    is_interior;
    logic                    is_border;
    t_line                   lb_rd;
    t_line                   lb_wr;
    t_col                    s1_col;
    logic [MAC_STAGES-1:0]   mac_v;
    logic                    mac_res_v;
    t_tag                    mac_tag;
    t_pix                    mac_value;
    t_res                    res_int;
    t_res                    res_bdr;
    t_push                   push0;
    t_push                   push1;
    t_res                    fifo_res;
    logic [FIFO_CNT_W-1:0]   fifo_cnt;
    logic [INFL_W-1:0]       inflight;
    logic [CRED_W-1:0]       credit_need;

    // Configuration: geometry is stored already clamped to its legal range.
    assign cfg_w = i_cfg_data[WIDTH_CFG_W-1:0];
    assign cfg_h = i_cfg_data[HEIGHT_CFG_W-1:0];

    always_comb begin
        if (cfg_w == '0) begin
            n_width = (COL_W+1)'(1);
        end else if (int'(cfg_w) > MAX_WIDTH) begin
            n_width = (COL_W+1)'(MAX_WIDTH);
        end else begin
            n_width = (COL_W+1)'(cfg_w);
        end
        if (cfg_h == '0) begin
            n_height = HEIGHT_CFG_W'(1);
        end else if (int'(cfg_h) > MAX_HEIGHT) begin
            n_height = HEIGHT_CFG_W'(MAX_HEIGHT);
        end else begin
            n_height = cfg_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs     <= '0;
            r_normalize <= 1'b1;
            r_width     <= (COL_W+1)'(RESET_WIDTH);
            r_height    <= HEIGHT_CFG_W'(RESET_HEIGHT);
        end else if (i_cfg_valid && o_cfg_ready) begin
            for (int n = 0; n < AREA; n++) begin
                if (i_cfg_index == CFG_COEF_0 + CFG_IDX_W'(n / COEFS_PER_REG)) begin
                    r_coefs[n] <= i_cfg_data[(n % COEFS_PER_REG) * PIX_W +: PIX_W];
                end
            end
            case (i_cfg_index)
                CFG_NORMALIZE: r_normalize <= i_cfg_data[0];
                CFG_WIDTH:     r_width     <= n_width;
                CFG_HEIGHT:    r_height    <= n_height;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = (inflight == '0);

    // Every item in the pipeline is reserved two queue slots.
    assign inflight    = INFL_W'($countones({mac_v, r_s1_valid}));
    assign credit_need = CRED_W'(fifo_cnt) + CRED_W'(RES_PER_ITEM) * CRED_W'(inflight)
                       + CRED_W'(RES_PER_ITEM);
    assign o_stall     = (credit_need > CRED_W'(FIFO_DEPTH)) || i_cfg_valid;
    assign in_accept   = i_valid && !o_stall;

    // Raster position of the next item.
    assign col_inc = (COL_W+1)'(r_col) + (COL_W+1)'(1);
    assign row_inc = HEIGHT_CFG_W'(r_row) + HEIGHT_CFG_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_accept) begin
            if (col_inc >= r_width) begin
                r_col <= '0;
                r_row <= (row_inc >= r_height) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                r_col <= col_inc[COL_W-1:0];
            end
        end
    end

    // An item completes a window when it sits at least K-1 rows and columns
    // into the frame; it is a border pixel within K/2 of any edge.
    always_comb begin
        is_interior = (r_row >= ROW_W'(2*HALF)) && (r_col >= COL_W'(2*HALF))
                   && (HEIGHT_CFG_W'(r_row) < r_height)
                   && ((COL_W+1)'(r_col) < r_width);
        is_border   = (r_row < ROW_W'(HALF)) || (r_col < COL_W'(HALF))
                   || (HEIGHT_CFG_W'(r_row) + HEIGHT_CFG_W'(HALF) >= r_height)
                   || ((COL_W+1)'(r_col) + (COL_W+1)'(HALF) >= r_width);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_tag.interior <= is_interior;
            r_s1_tag.border   <= is_border;
            r_s1_tag.pixel    <= i_pixel;
            r_s1_tag.row      <= r_row;
            r_s1_tag.col      <= r_col;
        end
    end

    // Read-modify-write of the line buffer: the oldest row drops out and the
    // new pixel is appended at its column.
    always_comb begin
        for (int j = 0; j < KERNEL_SIZE - 2; j++) begin
            lb_wr[j] = lb_rd[j+1];
        end
        lb_wr[KERNEL_SIZE-2] = r_s1_tag.pixel;
        for (int i = 0; i < KERNEL_SIZE - 1; i++) begin
            s1_col[i] = lb_rd[i];
        end
        s1_col[KERNEL_SIZE-1] = r_s1_tag.pixel;
    end

    ic2d_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_col),
        .o_rd_data (lb_rd),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_tag.col),
        .i_wr_data (lb_wr)
    );

    ic2d_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_shift     (r_s1_valid),
        .i_col       (s1_col),
        .i_tag       (r_s1_tag),
        .i_coefs     (r_coefs),
        .i_normalize (r_normalize),
        .o_stage_v   (mac_v),
        .o_res_v     (mac_res_v),
        .o_tag       (mac_tag),
        .o_value     (mac_value)
    );

    always_comb begin
        res_int.pixel    = mac_value;
        res_int.row      = mac_tag.row - ROW_W'(HALF);
        res_int.col      = OUT_COL_W'(mac_tag.col - COL_W'(HALF));
        res_int.filtered = 1'b1;
        res_int.last     = !mac_tag.border;

        res_bdr.pixel    = mac_tag.pixel;
        res_bdr.row      = mac_tag.row;
        res_bdr.col      = OUT_COL_W'(mac_tag.col);
        res_bdr.filtered = 1'b0;
        res_bdr.last     = 1'b1;

        push0.valid = mac_res_v && (mac_tag.interior || mac_tag.border);
        push0.res   = mac_tag.interior ? res_int : res_bdr;
        push1.valid = mac_res_v && mac_tag.interior && mac_tag.border;
        push1.res   = res_bdr;
    end

    ic2d_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_push1 (push1),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (fifo_res),
        .o_count (fifo_cnt)
    );

    assign o_pixel_out    = fifo_res.pixel;
    assign o_out_row      = fifo_res.row;
    assign o_out_column   = fifo_res.col;
    assign o_is_filtered  = fifo_res.filtered;
    assign o_last_of_item = fifo_res.last;

endmodule
